/* design/dsc_pkg.sv */
// ----------------------------------------------------------------------------
// dsc_pkg: shared types and helpers for the digram square cipher
// Letter codes are a..z without j (0..24); cells are numbered row*5+column.
// ----------------------------------------------------------------------------
package dsc_pkg;

  localparam int unsigned SIDE  = 5;
  localparam int unsigned CELLS = SIDE * SIDE;
  localparam int unsigned CW    = $clog2(CELLS);  // cell / letter code width
  localparam int unsigned RW    = $clog2(SIDE);   // row / column width

  // Cipher modes
  localparam logic [1:0] MODE_TWO_DEC  = 2'd0;
  localparam logic [1:0] MODE_FOUR_DEC = 2'd1;
  localparam logic [1:0] MODE_FOUR_ENC = 2'd2;

  // Input request kinds (tuser)
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_DIGRAM = 1'b1;

  localparam logic [CW-1:0] LAST_CODE = CW'(CELLS - 1);

  // One cell write into a keyed square
  typedef struct packed {
    logic          en;
    logic          blank;
    logic [CW-1:0] pos;
    logic [CW-1:0] letter;
  } cell_wr_t;

  // Inverse map entry: where a letter sits
  typedef struct packed {
    logic          placed;
    logic [CW-1:0] pos;
  } inv_ent_t;

  // Cell entry: which letter a cell holds
  typedef struct packed {
    logic          occ;
    logic [CW-1:0] letter;
  } cell_ent_t;

  // What one lane found for its letter
  typedef struct packed {
    logic          found;
    logic [RW-1:0] row;
    logic [RW-1:0] col;
  } lane_res_t;

  // Pair result handed to the output register
  typedef struct packed {
    logic          v2;
    logic          v1;
    logic [CW-1:0] o2;
    logic [CW-1:0] o1;
  } pair_res_t;

  // cell / 5 for cell < 25, as (cell*13) >> 6
  function automatic logic [RW-1:0] cell_row(input logic [CW-1:0] c);
    logic [8:0] p;
    p = {4'b0, c} * 9'd13;
    return p[8:6];
  endfunction

  // cell % 5
  function automatic logic [RW-1:0] cell_col(input logic [CW-1:0] c);
    logic [CW-1:0] r;
    logic [CW-1:0] d;
    r = {2'b0, cell_row(c)};
    d = c - ((r << 2) + r);
    return d[RW-1:0];
  endfunction

  // row*5 + column
  function automatic logic [CW-1:0] cell_index(input logic [RW-1:0] r,
                                               input logic [RW-1:0] c);
    logic [CW-1:0] rr;
    rr = {2'b0, r};
    return (rr << 2) + rr + {2'b0, c};
  endfunction

endpackage

/* design/digram_square_cipher.sv */
// ----------------------------------------------------------------------------
// digram_square_cipher: two-square / four-square digram cipher core
//
// Channel  Dir  Handshake              Payload
// s_axis   in   tvalid/tready          tuser: command; tdata: load and digram fields
// m_axis   out  tvalid/tready          tdata: letters; tuser: valid flags
// cfg      in   cfg_valid_i/cfg_ready_o  cfg_data_i: mode
//
// Flow: one request per cycle while s_axis_tready is high. A digram is
//   located by two lanes in the cycle it is accepted (inverse maps, or the
//   plain square in four-square encipher), crossed and read out of the keyed
//   squares in the next, and shows on m_axis from the output register.
// Loads write the squares at their accepting edge and return nothing.
// Reset: all cells empty, all letters unplaced, mode two-square decipher.
// Stalls: the output register holds a finished pair while the lane stage
//   keeps one more; s_axis stalls only when both are full and m_axis stalls.
// ----------------------------------------------------------------------------
module digram_square_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  // [0] square_select, [5:1] cell_position, [10:6] cell_letter,
  // [11] cell_blank, [16:12] first_letter, [21:17] second_letter, [23:22] zero
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tuser,    // [0] command
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] out_first, [9:5] out_second, [15:10] zero
  output logic [15:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,    // [0] first_valid, [1] second_valid
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i       // mode
);
  import dsc_pkg::*;

  // request fields
  logic          square_select;
  logic [CW-1:0] cell_position;
  logic [CW-1:0] cell_letter;
  logic          cell_blank;
  logic [CW-1:0] first_letter;
  logic [CW-1:0] second_letter;

  assign square_select = s_axis_tdata[0];
  assign cell_position = s_axis_tdata[5:1];
  assign cell_letter   = s_axis_tdata[10:6];
  assign cell_blank    = s_axis_tdata[11];
  assign first_letter  = s_axis_tdata[16:12];
  assign second_letter = s_axis_tdata[21:17];

  // mode register
  logic [1:0] mode_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_TWO_DEC;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // pipeline control
  logic       s1_valid_q, s1_valid_d;
  logic [1:0] s1_mode_q;
  logic       out_valid_q, out_valid_d;
  logic       s1_adv;
  logic       in_acc;
  logic       dig_acc;
  logic       load_acc;

  // stage 1 can move on when the output register is free or being drained
  assign s1_adv        = !out_valid_q || m_axis_tready;
  // loads also wait for a stalled digram so it still reads the old squares
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign dig_acc       = in_acc && (s_axis_tuser == CMD_DIGRAM);
  assign load_acc      = in_acc && (s_axis_tuser == CMD_LOAD);

  // square writes
  cell_wr_t wr0, wr1;
  always_comb begin
    wr0.en     = load_acc && !square_select && (cell_position <= LAST_CODE);
    wr0.blank  = cell_blank;
    wr0.pos    = cell_position;
    wr0.letter = cell_letter;
    wr1        = wr0;
    wr1.en     = load_acc && square_select && (cell_position <= LAST_CODE);
  end

  // inverse map lookups: two-square decipher finds the first letter in
  // square two and the second in square one, four-square the other way
  logic [CW-1:0] inv0_addr, inv1_addr;
  inv_ent_t      inv0, inv1;
  assign inv0_addr = (mode_q == MODE_TWO_DEC) ? second_letter : first_letter;
  assign inv1_addr = (mode_q == MODE_TWO_DEC) ? first_letter  : second_letter;

  logic [CW-1:0] addr1, addr2;
  cell_ent_t     cell1, cell2;

  dsc_square u_square_one (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr0),
    .inv_addr_i  (inv0_addr),
    .inv_o       (inv0),
    .cell_addr_i (addr1),
    .cell_o      (cell1)
  );

  dsc_square u_square_two (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr1),
    .inv_addr_i  (inv1_addr),
    .inv_o       (inv1),
    .cell_addr_i (addr2),
    .cell_o      (cell2)
  );

  // lanes: one per digram letter
  lane_res_t lane0, lane1;

  dsc_lane u_lane_first (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (dig_acc),
    .mode_i     (mode_q),
    .letter_i   (first_letter),
    .ent_two_i  (inv1),
    .ent_four_i (inv0),
    .res_o      (lane0)
  );

  dsc_lane u_lane_second (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (dig_acc),
    .mode_i     (mode_q),
    .letter_i   (second_letter),
    .ent_two_i  (inv0),
    .ent_four_i (inv1),
    .res_o      (lane1)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (dig_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dig_acc) begin
      s1_mode_q <= mode_q;
    end
  end

  // merge: cross rows and columns, read the keyed cells
  pair_res_t pair_d, pair_q;

  dsc_merge u_merge (
    .mode_i  (s1_mode_q),
    .lane0_i (lane0),
    .lane1_i (lane1),
    .addr1_o (addr1),
    .addr2_o (addr2),
    .cell1_i (cell1),
    .cell2_i (cell2),
    .res_o   (pair_d)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_valid_q && s1_adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      pair_q <= pair_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, pair_q.o2, pair_q.o1};
  assign m_axis_tuser  = {pair_q.v2, pair_q.v1};

  // ------------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------------

  // a digram held in stage 1 behind a stalled output blocks new requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken while stage 1 is blocked");

  // four-square decipher with both letters placed always gives two letters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_adv && (s1_mode_q == MODE_FOUR_DEC) && lane0.found && lane1.found
    |=> m_axis_tvalid && (m_axis_tuser == 2'b11))
    else $error("four-square decipher pair not valid");

  // a blank first output carries a zero letter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[4:0] == '0))
    else $error("blank first letter not zero");

  // a digram accepted into an empty pipe reaches the output through the lane and output registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig_acc && !s1_valid_q && !out_valid_q |=> ##1 m_axis_tvalid)
    else $error("digram result missing");

endmodule

/* design/dsc_square.sv */
// ----------------------------------------------------------------------------
// dsc_square: one keyed 5x5 square with its letter-to-cell inverse map
// Cell writes land at the edge; both read ports are combinational.
// ----------------------------------------------------------------------------
module dsc_square (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dsc_pkg::cell_wr_t         wr_i,
  input  logic [dsc_pkg::CW-1:0]    inv_addr_i,
  output dsc_pkg::inv_ent_t         inv_o,
  input  logic [dsc_pkg::CW-1:0]    cell_addr_i,
  output dsc_pkg::cell_ent_t        cell_o
);
  import dsc_pkg::*;

  logic [CELLS-1:0] occ_q;
  logic [CW-1:0]    let_q [CELLS];
  logic [CELLS-1:0] placed_q;
  logic [CW-1:0]    pos_q [CELLS];

  logic set_cell;
  assign set_cell = wr_i.en && !wr_i.blank && (wr_i.letter <= LAST_CODE);

  // occupancy / placed flags are cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q    <= '0;
      placed_q <= '0;
    end else if (wr_i.en) begin
      if (wr_i.blank) begin
        occ_q[wr_i.pos] <= 1'b0;
      end else if (set_cell) begin
        occ_q[wr_i.pos]       <= 1'b1;
        placed_q[wr_i.letter] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (set_cell) begin
      let_q[wr_i.pos]    <= wr_i.letter;
      pos_q[wr_i.letter] <= wr_i.pos;
    end
  end

  always_comb begin
    inv_o = '0;
    if (inv_addr_i <= LAST_CODE) begin
      inv_o.placed = placed_q[inv_addr_i];
      inv_o.pos    = pos_q[inv_addr_i];
    end
  end

  always_comb begin
    cell_o = '0;
    if (cell_addr_i <= LAST_CODE) begin
      cell_o.occ    = occ_q[cell_addr_i];
      cell_o.letter = let_q[cell_addr_i];
    end
  end

endmodule

/* design/dsc_lane.sv */
// ----------------------------------------------------------------------------
// dsc_lane: locates one digram letter and registers its row and column
// Two-square and four-square decipher use the keyed inverse maps, four-square
// encipher uses the fixed plain square.
// ----------------------------------------------------------------------------
module dsc_lane (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic [1:0]                mode_i,
  input  logic [dsc_pkg::CW-1:0]    letter_i,
  input  dsc_pkg::inv_ent_t         ent_two_i,   // entry used in two-square decipher
  input  dsc_pkg::inv_ent_t         ent_four_i,  // entry used in four-square decipher
  output dsc_pkg::lane_res_t        res_o
);
  import dsc_pkg::*;

  logic          found;
  logic [CW-1:0] cell_idx;
  lane_res_t     res_d;
  logic          found_q;
  logic [RW-1:0] row_q;
  logic [RW-1:0] col_q;

  always_comb begin
    found    = 1'b0;
    cell_idx = '0;
    case (mode_i)
      MODE_TWO_DEC: begin
        found    = ent_two_i.placed && (ent_two_i.pos <= LAST_CODE);
        cell_idx = ent_two_i.pos;
      end
      MODE_FOUR_DEC: begin
        found    = ent_four_i.placed && (ent_four_i.pos <= LAST_CODE);
        cell_idx = ent_four_i.pos;
      end
      MODE_FOUR_ENC: begin
        found    = letter_i <= LAST_CODE;
        cell_idx = letter_i;
      end
      default: begin
        found    = 1'b0;
        cell_idx = '0;
      end
    endcase
    res_d.found = found;
    res_d.row   = cell_row(cell_idx);
    res_d.col   = cell_col(cell_idx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (load_i) begin
      found_q <= res_d.found;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      row_q <= res_d.row;
      col_q <= res_d.col;
    end
  end

  assign res_o = {found_q, row_q, col_q};

endmodule

/* design/dsc_merge.sv */
// ----------------------------------------------------------------------------
// dsc_merge: crosses the lanes' rows and columns into the output pair
// First output takes lane 0's row and lane 1's column, second the reverse.
// ----------------------------------------------------------------------------
module dsc_merge (
  input  logic [1:0]                mode_i,
  input  dsc_pkg::lane_res_t        lane0_i,
  input  dsc_pkg::lane_res_t        lane1_i,
  output logic [dsc_pkg::CW-1:0]    addr1_o,   // cell read in square one
  output logic [dsc_pkg::CW-1:0]    addr2_o,   // cell read in square two
  input  dsc_pkg::cell_ent_t        cell1_i,
  input  dsc_pkg::cell_ent_t        cell2_i,
  output dsc_pkg::pair_res_t        res_o
);
  import dsc_pkg::*;

  logic found;

  assign found   = lane0_i.found && lane1_i.found;
  assign addr1_o = cell_index(lane0_i.row, lane1_i.col);
  assign addr2_o = cell_index(lane1_i.row, lane0_i.col);

  always_comb begin
    res_o = '0;
    if (found) begin
      case (mode_i)
        MODE_FOUR_DEC: begin
          res_o.v1 = 1'b1;
          res_o.o1 = addr1_o;
          res_o.v2 = 1'b1;
          res_o.o2 = addr2_o;
        end
        MODE_TWO_DEC, MODE_FOUR_ENC: begin
          res_o.v1 = cell1_i.occ;
          res_o.o1 = cell1_i.occ ? cell1_i.letter : '0;
          res_o.v2 = cell2_i.occ;
          res_o.o2 = cell2_i.occ ? cell2_i.letter : '0;
        end
        default: begin
          res_o = '0;
        end
      endcase
    end
  end

endmodule

/* bench/digram_square_cipher_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// digram_square_cipher_tb: self-checking bench for the digram square cipher
// Keeps a shadow copy of both keyed squares, their letter maps and the mode.
// Every accepted digram request gets its predicted pair queued, and each pair
// leaving m_axis is checked against the oldest one. Directed cases come
// first. Random load/digram traffic follows under several stall patterns.
// ----------------------------------------------------------------------------
module digram_square_cipher_tb;
  import dsc_pkg::*;

  // Mode code outside the defined set; the core answers with blank pairs
  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam int SEGMENT_REQS = 105;   // random requests per mode segment
  localparam int DRAIN_LIMIT  = 5000;  // cycles allowed for results to drain
  localparam int SETTLE_CYCLES = 4;    // pipeline depth plus margin

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = CMD_LOAD;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i = MODE_TWO_DEC;

  // Shadow state of the core
  cell_ent_t   key_cells   [2][CELLS];
  inv_ent_t    letter_home [2][CELLS];
  logic [1:0]  cipher_mode;
  pair_res_t   pending_pairs[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;

  digram_square_cipher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #2_000_000;
    $display("digram_square_cipher_tb: done, errors");
    $finish;
  end

  task automatic note_error(string what, int want, int got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic void clear_squares();
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < CELLS; i++) begin
        key_cells[s][i]   = '0;
        letter_home[s][i] = '0;
      end
    end
    cipher_mode = MODE_TWO_DEC;
  endfunction

  // A load out of range is dropped; a blank load empties the cell but leaves
  // the letter map alone, so an old letter may still point at it.
  function automatic void apply_load(logic sq, logic [4:0] pos, logic [4:0] letter,
                                     logic blank);
    if (pos >= CELLS) return;
    if (blank) begin
      key_cells[sq][pos] = '0;
      return;
    end
    if (letter >= CELLS) return;
    key_cells[sq][pos].occ    = 1'b1;
    key_cells[sq][pos].letter = letter;
    letter_home[sq][letter].placed = 1'b1;
    letter_home[sq][letter].pos    = pos;
  endfunction

  function automatic void take_letter(int sq, int idx, output logic v,
                                      output logic [4:0] o);
    v = key_cells[sq][idx].occ;
    o = v ? key_cells[sq][idx].letter : 5'd0;
  endfunction

  // Rectangle rule: rows stay with their letter, columns are crossed
  function automatic pair_res_t cipher_pair(logic [4:0] a, logic [4:0] b);
    pair_res_t r;
    int ca, cb;
    r = '0;
    case (cipher_mode)
      MODE_TWO_DEC: begin
        if (a < CELLS && b < CELLS && letter_home[1][a].placed &&
            letter_home[0][b].placed) begin
          ca = letter_home[1][a].pos;
          cb = letter_home[0][b].pos;
          take_letter(0, (ca / SIDE) * SIDE + cb % SIDE, r.v1, r.o1);
          take_letter(1, (cb / SIDE) * SIDE + ca % SIDE, r.v2, r.o2);
        end
      end
      MODE_FOUR_DEC: begin
        // result letters come straight from the plain square
        if (a < CELLS && b < CELLS && letter_home[0][a].placed &&
            letter_home[1][b].placed) begin
          ca = letter_home[0][a].pos;
          cb = letter_home[1][b].pos;
          r.o1 = 5'((ca / SIDE) * SIDE + cb % SIDE);
          r.o2 = 5'((cb / SIDE) * SIDE + ca % SIDE);
          r.v1 = 1'b1;
          r.v2 = 1'b1;
        end
      end
      MODE_FOUR_ENC: begin
        if (a < CELLS && b < CELLS) begin
          take_letter(0, (a / SIDE) * SIDE + b % SIDE, r.v1, r.o1);
          take_letter(1, (b / SIDE) * SIDE + a % SIDE, r.v2, r.o2);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  // tdata: [0] square_select, [5:1] cell_position, [10:6] cell_letter,
  // [11] cell_blank, [16:12] first_letter, [21:17] second_letter
  function automatic logic [23:0] pack_request(logic sq, logic [4:0] pos,
      logic [4:0] letter, logic blank, logic [4:0] a, logic [4:0] b);
    return {2'b00, b, a, blank, letter, pos, sq};
  endfunction

  // One request through s_axis; shadow state is updated at the accepting edge
  task automatic send_item(logic cmd, logic [23:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (cmd == CMD_LOAD)
      apply_load(word[0], word[5:1], word[10:6], word[11]);
    else
      pending_pairs.push_back(cipher_pair(word[16:12], word[21:17]));
  endtask

  // Unused fields carry random bits so every tdata bit but [23:22] toggles
  task automatic send_load(logic sq, logic [4:0] pos, logic [4:0] letter, logic blank);
    send_item(CMD_LOAD, pack_request(sq, pos, letter, blank,
              5'($urandom_range(31)), 5'($urandom_range(31))));
  endtask

  task automatic send_digram(logic [4:0] a, logic [4:0] b);
    send_item(CMD_DIGRAM, pack_request(1'($urandom_range(1)), 5'($urandom_range(31)),
              5'($urandom_range(31)), 1'($urandom_range(1)), a, b));
  endtask

  // Loads return nothing, so let the pipeline settle after the last pair
  task automatic wait_idle();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_pairs.size() != 0 && guard < DRAIN_LIMIT) begin
      guard++;
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_mode(logic [1:0] m);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cipher_mode = m;
    cfg_valid_i <= 1'b0;
  endtask

  // Fresh keyed square from a shuffled alphabet, a few cells left blank
  task automatic rekey_square(logic sq);
    int perm[CELLS];
    int j, t;
    for (int i = 0; i < CELLS; i++) perm[i] = i;
    for (int i = CELLS - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (int i = 0; i < CELLS; i++)
      send_load(sq, 5'(i), 5'(perm[i]), $urandom_range(99) < 5);
  endtask

  function automatic logic [4:0] pick_letter();
    return ($urandom_range(99) < 90) ? 5'($urandom_range(CELLS - 1))
                                     : 5'($urandom_range(31, CELLS));
  endfunction

  // One random request or square rekey; n returns how many requests the core acted on
  task automatic random_request(output int n);
    int r;
    logic [4:0] pos;
    r = $urandom_range(99);
    if (r < 1) begin
      rekey_square(1'($urandom_range(1)));
      n = CELLS;
    end else if (r < 20) begin
      pos = pick_letter();
      send_load(1'($urandom_range(1)), pos, pick_letter(), $urandom_range(99) < 10);
      n = (pos < CELLS) ? 1 : 0;
    end else begin
      send_digram(pick_letter(), pick_letter());
      n = 1;
    end
  endtask

  // ---------------------------------------------------------------- checker

  always @(posedge clk_i) begin : pair_check
    pair_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pairs.size() == 0) begin
        note_error("pair with nothing pending", 0, m_axis_tdata[9:0]);
      end else begin
        want = pending_pairs.pop_front();
        if (m_axis_tdata[4:0] !== want.o1)
          note_error("out_first", want.o1, m_axis_tdata[4:0]);
        if (m_axis_tuser[0] !== want.v1)
          note_error("first_valid", want.v1, m_axis_tuser[0]);
        if (m_axis_tdata[9:5] !== want.o2)
          note_error("out_second", want.o2, m_axis_tdata[9:5]);
        if (m_axis_tuser[1] !== want.v2)
          note_error("second_valid", want.v2, m_axis_tuser[1]);
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------- tests

  // Nothing loaded yet: every letter is unplaced
  task automatic test_empty_squares();
    send_digram(5'd0, 5'd24);
    send_digram(5'd24, 5'd0);
  endtask

  // Two-square deciphering around a hand-built corner of both squares
  task automatic test_special_cases();
    send_load(1'b1, 5'd0, 5'd24, 1'b0);
    send_load(1'b0, 5'd24, 5'd0, 1'b0);
    send_load(1'b0, 5'd4, 5'd12, 1'b0);
    send_digram(5'd24, 5'd0);            // second output hits an empty cell
    send_load(1'b1, 5'd20, 5'd31, 1'b0); // letter out of range, dropped
    send_load(1'b1, 5'd31, 5'd5, 1'b0);  // position out of range, dropped
    send_load(1'b1, 5'd20, 5'd7, 1'b0);
    send_digram(5'd24, 5'd0);            // both outputs present
    send_digram(5'd31, 5'd0);            // letter code past the alphabet
    send_digram(5'd5, 5'd0);             // letter never placed
    send_load(1'b0, 5'd4, 5'd12, 1'b1);  // blank load keeps the letter map
    send_digram(5'd24, 5'd0);
    send_load(1'b0, 5'd24, 5'd3, 1'b0);  // overwrite: stale map for letter 0
    send_digram(5'd24, 5'd0);
    send_load(1'b1, 5'd13, 5'd24, 1'b0); // same letter placed twice
    send_digram(5'd24, 5'd3);
  endtask

  task automatic test_mode_sweep();
    set_mode(MODE_FOUR_DEC);
    send_digram(5'd3, 5'd24);
    send_digram(5'd24, 5'd24);
    set_mode(MODE_FOUR_ENC);
    send_digram(5'd0, 5'd0);
    send_digram(5'd24, 5'd24);
    send_digram(5'd4, 5'd20);
    set_mode(MODE_RESERVED);
    send_digram(5'd24, 5'd0);
    set_mode(MODE_TWO_DEC);
  endtask

  // Random traffic in every mode under one stall pattern
  task automatic test_random_traffic(int idle_pct, int stall_pct);
    logic [1:0] modes[4];
    int done_reqs, n;
    modes = '{MODE_FOUR_ENC, MODE_TWO_DEC, MODE_RESERVED, MODE_FOUR_DEC};
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    rekey_square(1'b0);
    rekey_square(1'b1);
    foreach (modes[k]) begin
      set_mode(modes[k]);
      done_reqs = 0;
      while (done_reqs < SEGMENT_REQS) begin
        random_request(n);
        done_reqs += n;
      end
    end
  endtask

  initial begin
    clear_squares();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_squares();
    test_special_cases();
    test_mode_sweep();
    test_random_traffic(0, 0);
    test_random_traffic(59, 0);
    test_random_traffic(0, 59);
    test_random_traffic(17, 17);

    wait_idle();
    if (pending_pairs.size() != 0)
      note_error("pairs never delivered", 0, pending_pairs.size());
    if (mismatch_count == 0)
      $display("digram_square_cipher_tb: done, clean");
    else
      $display("digram_square_cipher_tb: done, errors");
    $finish;
  end

endmodule
